// File: design/fhp_pkg.sv
// Shared types and constants for the fire heat propagation unit.
// Used by fhp_alu, fhp_seq and the top level; depends on nothing.
`default_nettype none

package fhp_pkg;

  // Frame size defaults
  localparam int unsigned WidthDefault  = 320;
  localparam int unsigned HeightDefault = 240;

  // Hotspot span: 40 entries around the center, peak 20
  localparam int unsigned HotSpan  = 40;
  localparam int unsigned HalfSpan = HotSpan / 2;

  localparam logic [7:0] MaxHeatReset = 8'd255;

  // Constant ratios as multiply-and-shift, exact for 8-bit operands:
  //   v/5      = (v * 205)    >> 10
  //   v*62/100 = (v * 325066) >> 19
  //   v*19/20  = (v * 62260)  >> 16
  localparam logic [18:0] Div5Mul   = 19'd205;
  localparam logic [4:0]  Div5Shift = 5'd10;
  localparam logic [18:0] Mul62Mul  = 19'd325066;
  localparam logic [4:0]  Mul62Shift = 5'd19;
  localparam logic [18:0] Mul95Mul  = 19'd62260;
  localparam logic [4:0]  Mul95Shift = 5'd16;

  typedef enum logic [1:0] {
    OP_HEAT   = 2'd0,
    OP_UPDATE = 2'd1,
    OP_READ   = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    FN_DIV5,
    FN_MUL62,
    FN_MUL95,
    FN_SATADD,
    FN_COOL
  } alu_fn_e;

  typedef struct packed {
    alu_fn_e    fn;
    logic [9:0] a;
    logic [7:0] b;
    logic [7:0] max_heat;
  } alu_req_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_OWN,
    ST_LEFT,
    ST_RIGHT,
    ST_CENTER,
    ST_COOL,
    ST_HMOD,
    ST_HEAT,
    ST_OUT
  } seq_state_e;

endpackage

`default_nettype wire

// File: design/fhp_alu.sv
// Shared arithmetic unit: one constant multiplier with shift, plus
// saturating add and cooling subtract. Depends on fhp_pkg.
`default_nettype none

module fhp_alu
  import fhp_pkg::*;
(
  input  alu_req_t   req_i,
  output logic [7:0] y_o
);

  logic [18:0] k;
  logic [4:0]  sh;
  logic [26:0] prod;
  logic [26:0] shifted;
  logic [8:0]  sum;
  logic [9:0]  diff;

  always_comb begin
    k  = Div5Mul;
    sh = Div5Shift;
    case (req_i.fn)
      FN_MUL62: begin
        k  = Mul62Mul;
        sh = Mul62Shift;
      end
      FN_MUL95: begin
        k  = Mul95Mul;
        sh = Mul95Shift;
      end
      default: begin
        k  = Div5Mul;
        sh = Div5Shift;
      end
    endcase

    prod    = 27'(req_i.a[7:0]) * 27'(k);
    shifted = prod >> sh;
    sum     = 9'(req_i.a[7:0]) + 9'(req_i.b);
    diff    = (req_i.a < 10'(req_i.b)) ? 10'd0 : req_i.a - 10'(req_i.b);

    case (req_i.fn)
      FN_SATADD: y_o = (sum > 9'(req_i.max_heat)) ? req_i.max_heat : sum[7:0];
      FN_COOL:   y_o = (diff > 10'(req_i.max_heat)) ? req_i.max_heat : diff[7:0];
      default:   y_o = shifted[7:0];
    endcase
  end

endmodule

`default_nettype wire

// File: design/fhp_frame_ram.sv
// Heat frame memory: one write port, one read port, registered read data.
// Depends on nothing beyond its parameters.
`default_nettype none

module fhp_frame_ram #(
  parameter int unsigned Depth = 76800,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [7:0]       wr_data_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [7:0]       rd_data_o
);

  logic [7:0] frame_mem [Depth];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      frame_mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= frame_mem[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

// File: design/fhp_seq.sv
// Sequencer of the fire heat unit: clears the frame, takes one word at a
// time and steps the frame memory and the shared ALU. Depends on fhp_pkg.
`default_nettype none

module fhp_seq
  import fhp_pkg::*;
#(
  parameter int unsigned WIDTH  = WidthDefault,
  parameter int unsigned HEIGHT = HeightDefault,
  parameter int unsigned Depth  = WIDTH * HEIGHT,
  parameter int unsigned AddrW  = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [1:0]       op_i,
  input  logic [8:0]       column_i,
  input  logic [7:0]       row_i,
  input  logic [3:0]       cooling_i,
  input  logic [7:0]       max_heat_i,
  output logic             res_valid_o,
  output logic [7:0]       res_level_o,
  input  logic             res_take_i,
  output logic             ram_wr_en_o,
  output logic [AddrW-1:0] ram_wr_addr_o,
  output logic [7:0]       ram_wr_data_o,
  output logic             ram_rd_en_o,
  output logic [AddrW-1:0] ram_rd_addr_o,
  input  logic [7:0]       ram_rd_data_i,
  output alu_req_t         alu_req_o,
  input  logic [7:0]       alu_y_i
);

  localparam int unsigned ColW    = $clog2(WIDTH);
  localparam int unsigned CenW    = (ColW >= 9) ? ColW + 1 : 9;
  localparam int unsigned BotBase = (HEIGHT - 1) * WIDTH;

  seq_state_e       state_q, state_d;
  logic [AddrW-1:0] clr_q, clr_d;
  op_e              op_q, op_d;
  logic [CenW-1:0]  cen_q, cen_d;
  logic [7:0]       row_q, row_d;
  logic [3:0]       cool_q, cool_d;
  logic             inr_q, inr_d;
  logic [AddrW-1:0] base_q, base_d;
  logic [5:0]       cnt_q, cnt_d;
  logic [ColW-1:0]  hcol_q, hcol_d;
  logic [ColW-1:0]  wcol_q, wcol_d;
  logic [9:0]       acc_q, acc_d;
  logic [7:0]       res_q, res_d;

  logic [ColW-1:0]  col, lc, rc, cen_r, hcol_next, hstart;
  logic [AddrW-1:0] own_addr, below_base;
  logic             is_top, is_bottom;
  logic [5:0]       step;
  logic [5:0]       add_k;

  always_comb begin
    col        = cen_q[ColW-1:0];
    lc         = (col == '0) ? ColW'(WIDTH - 1) : col - ColW'(1);
    rc         = (col == ColW'(WIDTH - 1)) ? '0 : col + ColW'(1);
    own_addr   = base_q + AddrW'(col);
    below_base = base_q + AddrW'(WIDTH);
    is_top     = (row_q == 8'd0);
    is_bottom  = ({24'd0, row_q} == 32'(HEIGHT - 1));
    cen_r      = cen_q[ColW-1:0];
    hstart     = (cen_r >= ColW'(HalfSpan)) ? cen_r - ColW'(HalfSpan)
                                            : cen_r + ColW'(WIDTH - HalfSpan);
    hcol_next  = (hcol_q == ColW'(WIDTH - 1)) ? '0 : hcol_q + ColW'(1);
    // Entry written this step sits at offset step-20 from the center
    step       = cnt_q - 6'd1;
    add_k      = (step < 6'(HalfSpan)) ? step : 6'(HotSpan) - step;
  end

  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    op_d    = op_q;
    cen_d   = cen_q;
    row_d   = row_q;
    cool_d  = cool_q;
    inr_d   = inr_q;
    base_d  = base_q;
    cnt_d   = cnt_q;
    hcol_d  = hcol_q;
    wcol_d  = wcol_q;
    acc_d   = acc_q;
    res_d   = res_q;

    in_stall_o    = 1'b1;
    res_valid_o   = 1'b0;
    ram_wr_en_o   = 1'b0;
    ram_wr_addr_o = own_addr;
    ram_wr_data_o = alu_y_i;
    ram_rd_en_o   = 1'b0;
    ram_rd_addr_o = own_addr;

    alu_req_o.fn       = FN_DIV5;
    alu_req_o.a        = {2'b00, ram_rd_data_i};
    alu_req_o.b        = 8'd0;
    alu_req_o.max_heat = max_heat_i;

    case (state_q)
      ST_CLEAR: begin
        ram_wr_en_o   = 1'b1;
        ram_wr_addr_o = clr_q;
        ram_wr_data_o = 8'd0;
        clr_d         = clr_q + AddrW'(1);
        if (clr_q == AddrW'(Depth - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          op_d    = op_e'(op_i);
          cen_d   = CenW'(column_i);
          row_d   = row_i;
          cool_d  = cooling_i;
          inr_d   = ({23'd0, column_i} < 32'(WIDTH)) && ({24'd0, row_i} < 32'(HEIGHT));
          base_d  = AddrW'({24'd0, row_i} * 32'(WIDTH));
          state_d = ST_DECODE;
        end
      end
      ST_DECODE: begin
        case (op_q)
          OP_HEAT: begin
            state_d = ST_HMOD;
          end
          OP_UPDATE, OP_READ: begin
            if (!inr_q) begin
              res_d   = 8'd0;
              state_d = ST_OUT;
            end else if (op_q == OP_UPDATE && !is_top && !is_bottom) begin
              ram_rd_en_o   = 1'b1;
              ram_rd_addr_o = below_base + AddrW'(lc);
              state_d       = ST_LEFT;
            end else begin
              ram_rd_en_o   = 1'b1;
              ram_rd_addr_o = own_addr;
              state_d       = ST_OWN;
            end
          end
          default: begin
            res_d   = 8'd0;
            state_d = ST_OUT;
          end
        endcase
      end
      ST_OWN: begin
        if (op_q == OP_UPDATE && is_bottom) begin
          alu_req_o.fn = FN_MUL95;
          ram_wr_en_o  = 1'b1;
          res_d        = alu_y_i;
        end else begin
          res_d = ram_rd_data_i;
        end
        state_d = ST_OUT;
      end
      ST_LEFT: begin
        alu_req_o.fn  = FN_DIV5;
        acc_d         = 10'(alu_y_i);
        ram_rd_en_o   = 1'b1;
        ram_rd_addr_o = below_base + AddrW'(rc);
        state_d       = ST_RIGHT;
      end
      ST_RIGHT: begin
        alu_req_o.fn  = FN_DIV5;
        acc_d         = acc_q + 10'(alu_y_i);
        ram_rd_en_o   = 1'b1;
        ram_rd_addr_o = below_base + AddrW'(col);
        state_d       = ST_CENTER;
      end
      ST_CENTER: begin
        alu_req_o.fn = FN_MUL62;
        acc_d        = acc_q + 10'(alu_y_i);
        state_d      = ST_COOL;
      end
      ST_COOL: begin
        alu_req_o.fn = FN_COOL;
        alu_req_o.a  = acc_q;
        alu_req_o.b  = {4'd0, cool_q};
        ram_wr_en_o  = 1'b1;
        res_d        = alu_y_i;
        state_d      = ST_OUT;
      end
      ST_HMOD: begin
        // Reduce the center column one subtract per cycle
        if (cen_q >= CenW'(WIDTH)) begin
          cen_d = cen_q - CenW'(WIDTH);
        end else begin
          hcol_d  = hstart;
          cnt_d   = 6'd0;
          state_d = ST_HEAT;
        end
      end
      ST_HEAT: begin
        // Read entry cnt while writing back entry cnt-1
        if (cnt_q < 6'(HotSpan)) begin
          ram_rd_en_o   = 1'b1;
          ram_rd_addr_o = AddrW'(BotBase) + AddrW'(hcol_q);
          hcol_d        = hcol_next;
          wcol_d        = hcol_q;
        end
        if (cnt_q != 6'd0) begin
          alu_req_o.fn  = FN_SATADD;
          alu_req_o.b   = 8'(add_k);
          ram_wr_en_o   = 1'b1;
          ram_wr_addr_o = AddrW'(BotBase) + AddrW'(wcol_q);
          if (step == 6'(HalfSpan)) begin
            res_d = alu_y_i;
          end
        end
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'(HotSpan)) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        res_valid_o = 1'b1;
        if (res_take_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign res_level_o = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    cen_q  <= cen_d;
    row_q  <= row_d;
    cool_q <= cool_d;
    inr_q  <= inr_d;
    base_q <= base_d;
    cnt_q  <= cnt_d;
    hcol_q <= hcol_d;
    wcol_q <= wcol_d;
    acc_q  <= acc_d;
    res_q  <= res_d;
  end

endmodule

`default_nettype wire

// File: design/fire_effect_heat_propagation_unit.sv
// Top level of the fire heat propagation unit: the max_heat configuration register,
// output register, and the sequencer, shared ALU and frame memory.
// Depends on fhp_pkg, fhp_alu, fhp_frame_ram and fhp_seq.
`default_nettype none

// The unit keeps a WIDTH x HEIGHT frame of 8-bit heat levels in a single
// frame memory with one read and one write port, and works on one input
// word at a time through a small sequencer and one shared arithmetic unit
// (a constant multiply-and-shift, a saturating add and a cooling subtract).
// After reset a clearing pass writes zero to every entry, one per cycle;
// in_stall_o stays high meanwhile, while max_heat writes are taken as usual.
// A read decodes, reads its own entry and offers it; an out-of-range or
// unused op offers zero straight after decode. An update on the top or
// bottom row goes the way of a read, the bottom row writing its decayed
// level back; an interior update reads its three neighbors one per cycle
// from the single read port, then cools and writes back. A hotspot first
// subtracts WIDTH from the center column until it is below WIDTH, then runs
// its 40-entry read/write sweep. The result sits in an output register, so
// a new word is accepted while the previous result waits behind out_stall_i.
module fire_effect_heat_propagation_unit
  import fhp_pkg::*;
#(
  parameter int unsigned WIDTH  = WidthDefault,
  parameter int unsigned HEIGHT = HeightDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input words
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  op_i,
  input  logic [8:0]  column_i,
  input  logic [7:0]  row_i,
  input  logic [3:0]  cooling_i,
  // result words
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  level_o
);

  localparam int unsigned Depth = WIDTH * HEIGHT;
  localparam int unsigned AddrW = $clog2(Depth);

  // Register index taken from the word address
  localparam logic RegMaxHeat = 1'b0;

  logic [7:0]       max_heat_q, max_heat_d;
  logic             out_valid_q, out_valid_d;
  logic [7:0]       level_q, level_d;

  logic             res_valid;
  logic [7:0]       res_level;
  logic             res_take;

  logic             ram_wr_en;
  logic [AddrW-1:0] ram_wr_addr;
  logic [7:0]       ram_wr_data;
  logic             ram_rd_en;
  logic [AddrW-1:0] ram_rd_addr;
  logic [7:0]       ram_rd_data;

  alu_req_t         alu_req;
  logic [7:0]       alu_y;

  // Configuration: write max_heat in the access phase, read it back
  assign pready = 1'b1;

  always_comb begin
    max_heat_d = max_heat_q;
    if (psel && penable && pwrite && pready && (paddr[2] == RegMaxHeat)) begin
      max_heat_d = pwdata[7:0];
    end
    prdata = (paddr[2] == RegMaxHeat) ? {24'd0, max_heat_q} : 32'd0;
  end

  // Output register: load when empty or being drained this cycle
  assign res_take = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    level_d     = level_q;
    if (res_valid && res_take) begin
      out_valid_d = 1'b1;
      level_d     = res_level;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign level_o     = level_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_heat_q  <= MaxHeatReset;
      out_valid_q <= 1'b0;
    end else begin
      max_heat_q  <= max_heat_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    level_q <= level_d;
  end

  fhp_seq #(
    .WIDTH  (WIDTH),
    .HEIGHT (HEIGHT),
    .Depth  (Depth),
    .AddrW  (AddrW)
  ) u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .op_i          (op_i),
    .column_i      (column_i),
    .row_i         (row_i),
    .cooling_i     (cooling_i),
    .max_heat_i    (max_heat_q),
    .res_valid_o   (res_valid),
    .res_level_o   (res_level),
    .res_take_i    (res_take),
    .ram_wr_en_o   (ram_wr_en),
    .ram_wr_addr_o (ram_wr_addr),
    .ram_wr_data_o (ram_wr_data),
    .ram_rd_en_o   (ram_rd_en),
    .ram_rd_addr_o (ram_rd_addr),
    .ram_rd_data_i (ram_rd_data),
    .alu_req_o     (alu_req),
    .alu_y_i       (alu_y)
  );

  fhp_alu u_alu (
    .req_i (alu_req),
    .y_o   (alu_y)
  );

  fhp_frame_ram #(
    .Depth (Depth),
    .AddrW (AddrW)
  ) u_frame_ram (
    .clk_i     (clk_i),
    .wr_en_i   (ram_wr_en),
    .wr_addr_i (ram_wr_addr),
    .wr_data_i (ram_wr_data),
    .rd_en_i   (ram_rd_en),
    .rd_addr_i (ram_rd_addr),
    .rd_data_o (ram_rd_data)
  );

  // One word in flight: after taking a word, hold off the next one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input taken while a word is still in work");

  // A result only appears after the sequencer was busy with a word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(in_stall_o))
    else $error("result loaded without a word in work");

endmodule

`default_nettype wire

// File: tb/sv/tb_top.sv
// Self-checking testbench for fire_effect_heat_propagation_unit: directed edge cases,
// saturation, back-pressure and random traffic checked against a local frame model.
// Depends on fhp_pkg and the unit's RTL only.
`timescale 1ns / 100ps

module tb_top;
  import fhp_pkg::*;

  localparam int FrameW     = 320;
  localparam int FrameH     = 240;
  localparam int FrameCells = FrameW * FrameH;
  localparam int HalfWidth  = 20;          // hotspot reaches 20 columns left and 19 right
  localparam int HoldCycles = 300;         // long receiver hold-off
  localparam int QuietLimit = 250000;      // watchdog limit, longer than the clearing pass
  localparam int EndCycles  = 60;          // idle tail after the last drain
  localparam logic [2:0] MaxHeatAddr = 3'd0;
  localparam logic [1:0] OpUnused    = 2'd3;

  logic        clk_i;
  logic        rst_ni;
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [2:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  op_i      = '0;
  logic [8:0]  column_i  = '0;
  logic [7:0]  row_i     = '0;
  logic [3:0]  cooling_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [7:0]  level_o;

  // Local copy of the heat frame and the max_heat register
  logic [7:0] frame_model [FrameCells];
  logic [7:0] max_heat_model;
  logic [7:0] pending_levels [$];

  int fail_cnt    = 0;
  int quiet_cycles = 0;
  int idle_pct    = 0;
  int stall_pct   = 0;
  int hold_req    = 0;
  int hot_col     = 100;

  fire_effect_heat_propagation_unit #(
    .WIDTH  (FrameW),
    .HEIGHT (FrameH)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .op_i        (op_i),
    .column_i    (column_i),
    .row_i       (row_i),
    .cooling_i   (cooling_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .level_o     (level_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void flag_error(input string msg);
    if (fail_cnt < 10) $display("ERROR: %s", msg);
    fail_cnt++;
  endfunction

  // Apply one accepted word to the frame model and return the level it yields.
  function automatic logic [7:0] next_level(input logic [1:0] op, input logic [8:0] col,
                                            input logic [7:0] row, input logic [3:0] cool);
    int unsigned ctr, idx, sum, lc, rc, blw;
    int d, cc, mag;
    logic [7:0] lvl;
    lvl = '0;
    if (op == OP_HEAT) begin
      // center wraps modulo the frame width before the sweep
      ctr = col % FrameW;
      for (d = -HalfWidth; d < HalfWidth; d++) begin
        cc  = (int'(ctr) + d + FrameW) % FrameW;
        mag = (d < 0) ? -d : d;
        idx = (FrameH - 1) * FrameW + cc;
        sum = frame_model[idx] + HalfWidth - mag;
        // saturate even when the entry already sat above max_heat
        if (sum > max_heat_model) sum = max_heat_model;
        frame_model[idx] = 8'(sum);
      end
      lvl = frame_model[(FrameH - 1) * FrameW + ctr];
    end else if ((op == OP_UPDATE || op == OP_READ) && col < FrameW && row < FrameH) begin
      idx = row * FrameW + col;
      if (op == OP_UPDATE && row == FrameH - 1) begin
        // bottom-row decay, no saturation
        frame_model[idx] = 8'((frame_model[idx] * 19) / 20);
      end else if (op == OP_UPDATE && row != 0) begin
        lc  = (col == 0) ? FrameW - 1 : col - 1;
        rc  = (col == FrameW - 1) ? 0 : col + 1;
        blw = (row + 1) * FrameW;
        sum = frame_model[blw + lc] / 5 + frame_model[blw + rc] / 5
            + (frame_model[blw + col] * 62) / 100;
        sum = (sum < cool) ? 0 : sum - cool;
        if (sum > max_heat_model) sum = max_heat_model;
        frame_model[idx] = 8'(sum);
      end
      lvl = frame_model[idx];
    end
    // unused op and out-of-range entries return zero
    return lvl;
  endfunction

  // Check result words first, then record accepted input words, then run the watchdog.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_levels.size() == 0) begin
          flag_error($sformatf("result word with nothing pending, level %0d", level_o));
        end else if (pending_levels[0] !== level_o) begin
          flag_error($sformatf("level mismatch: expected %0d, got %0d",
                               pending_levels[0], level_o));
          void'(pending_levels.pop_front());
        end else begin
          void'(pending_levels.pop_front());
        end
      end
      if (in_valid_i && !in_stall_o) begin
        pending_levels.push_back(next_level(op_i, column_i, row_i, cooling_i));
      end
      if ((out_valid_o && !out_stall_i) || (in_valid_i && !in_stall_o)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QuietLimit) begin
        $display("watchdog: no word moved for %0d cycles", QuietLimit);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // Receiver side: random stalls, plus a long hold-off whenever hold_req changes.
  initial begin
    int hold_seen;
    int hold_left;
    hold_seen = 0;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HoldCycles;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // Offer one word, with random idle cycles ahead of it; return after acceptance.
  task automatic send_word(input logic [1:0] op, input logic [8:0] col,
                           input logic [7:0] row, input logic [3:0] cool);
    if ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    in_valid_i <= 1'b1;
    op_i       <= op;
    column_i   <= col;
    row_i      <= row;
    cooling_i  <= cool;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Drop valid and wait until every pending level has come back.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_levels.size() != 0) @(posedge clk_i);
  endtask

  // Write max_heat over APB, then read it back.
  task automatic set_max_heat(input logic [7:0] value);
    logic [31:0] rd;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= MaxHeatAddr;
    pwdata  <= {24'd0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    max_heat_model = value;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd !== {24'd0, value})
      flag_error($sformatf("max_heat readback: expected %0d, got %0d", value, rd));
  endtask

  // Hotspots, plus mostly updates and reads around the last one near the bottom
  // rows, so heat climbs the frame; the rest is out-of-range and unused-op noise.
  task automatic send_random();
    int pick, col, row, ctr;
    logic [3:0] cool;
    pick = $urandom_range(99);
    col  = int'((hot_col + FrameW + $urandom_range(48) - 24) % FrameW);
    row  = FrameH - 1 - $urandom_range(15);
    cool = 4'($urandom_range(8));
    if ($urandom_range(9) == 0) cool = 4'($urandom_range(15));
    if (pick < 18) begin
      ctr = ($urandom_range(9) == 0) ? $urandom_range(511) : $urandom_range(FrameW - 1);
      hot_col = ctr % FrameW;
      send_word(OP_HEAT, 9'(ctr), 8'($urandom_range(255)), 4'($urandom_range(15)));
    end else if (pick < 68) begin
      send_word(OP_UPDATE, 9'(col), 8'(row), cool);
    end else if (pick < 88) begin
      send_word(OP_READ, 9'(col), 8'(row), cool);
    end else if (pick < 95) begin
      send_word((pick < 92) ? OP_UPDATE : OP_READ, 9'($urandom_range(511)),
                8'($urandom_range(255)), 4'($urandom_range(15)));
    end else begin
      send_word(OpUnused, 9'($urandom_range(511)), 8'($urandom_range(255)),
                4'($urandom_range(15)));
    end
  endtask

  // Frame is clear after reset; hit wraparound, modulo center, row 0,
  // out-of-range entries, the unused op and the largest cooling.
  task automatic test_clear_and_edges();
    set_max_heat(8'd255);
    send_word(OP_READ,   9'd0,   8'd0,   4'd0);
    send_word(OP_READ,   9'd319, 8'd239, 4'd0);
    send_word(OP_HEAT,   9'd0,   8'd255, 4'd15);
    send_word(OP_HEAT,   9'd319, 8'd0,   4'd0);
    send_word(OP_HEAT,   9'd511, 8'd0,   4'd0);
    send_word(OP_HEAT,   9'd320, 8'd0,   4'd0);
    send_word(OP_UPDATE, 9'd0,   8'd239, 4'd0);
    send_word(OP_UPDATE, 9'd0,   8'd238, 4'd15);
    send_word(OP_UPDATE, 9'd319, 8'd238, 4'd8);
    send_word(OP_UPDATE, 9'd5,   8'd0,   4'd3);
    send_word(OP_UPDATE, 9'd1,   8'd1,   4'd0);
    send_word(OP_READ,   9'd320, 8'd0,   4'd0);
    send_word(OP_READ,   9'd0,   8'd240, 4'd0);
    send_word(OP_UPDATE, 9'd511, 8'd255, 4'd15);
    send_word(OpUnused,  9'd100, 8'd100, 4'd1);
    send_word(OP_READ,   9'd0,   8'd238, 4'd0);
    wait_drained();
  endtask

  // Saturation at max_heat, including entries already above a lowered max_heat.
  task automatic test_saturation();
    set_max_heat(8'd30);
    send_word(OP_HEAT, 9'd100, 8'd0, 4'd0);
    send_word(OP_HEAT, 9'd100, 8'd0, 4'd0);
    wait_drained();
    set_max_heat(8'd255);
    repeat (3) send_word(OP_HEAT, 9'd200, 8'd0, 4'd0);
    send_word(OP_UPDATE, 9'd200, 8'd238, 4'd0);
    wait_drained();
    set_max_heat(8'd1);
    send_word(OP_HEAT,   9'd200, 8'd0,   4'd0);
    send_word(OP_UPDATE, 9'd100, 8'd239, 4'd0);   // decay stays above max_heat
    send_word(OP_UPDATE, 9'd100, 8'd238, 4'd0);   // propagation clamps to max_heat
    send_word(OP_READ,   9'd200, 8'd239, 4'd0);
    wait_drained();
  endtask

  // Hold the result side for a long stretch while words keep coming.
  task automatic test_backpressure();
    set_max_heat(8'd255);
    idle_pct  = 0;
    stall_pct = 0;
    hold_req++;
    repeat (24) send_random();
    wait_drained();
  endtask

  task automatic run_traffic(input int sender_idle, input int recv_stall,
                             input logic [7:0] heat_cap, input int count);
    set_max_heat(heat_cap);
    idle_pct  = sender_idle;
    stall_pct = recv_stall;
    repeat (count) send_random();
    wait_drained();
  endtask

  task automatic test_random_traffic();
    run_traffic(0,  0,  8'd255, 230);
    run_traffic(57, 0,  8'd180, 230);
    run_traffic(0,  57, 8'd255, 230);
    run_traffic(22, 22, 8'($urandom_range(1, 255)), 230);
  endtask

  initial begin
    foreach (frame_model[i]) frame_model[i] = '0;
    max_heat_model = MaxHeatReset;
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_clear_and_edges();
    test_saturation();
    test_backpressure();
    test_random_traffic();
    wait_drained();
    repeat (EndCycles) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: filelist.f
design/fhp_pkg.sv
design/fhp_alu.sv
design/fhp_frame_ram.sv
design/fhp_seq.sv
design/fire_effect_heat_propagation_unit.sv
tb/sv/tb_top.sv
